// ===== rtl/rrts_pkg.sv =====
// Shared types, constants and command/status structs of the round-robin thread scheduler.
package rrts_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int COUNT_W   = SLOT_W + 1;
  localparam int PRIO_W    = 8;
  localparam int PID_W     = 16;
  localparam int KIND_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 8;

  localparam logic [SLOT_W-1:0] MAIN_SLOT_RST = SLOT_W'(0);
  localparam logic [SLOT_W-1:0] IDLE_SLOT_RST = SLOT_W'(1);
  localparam logic [PRIO_W-1:0] MAIN_PRIO_RST = PRIO_W'(31);
  localparam logic [PID_W-1:0]  PID_RST       = PID_W'(1);
  localparam logic [KIND_W-1:0] KIND_BAD      = KIND_W'(3);

  localparam logic [CFG_IDX_W-1:0] CFG_MAIN_SLOT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_SLOT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_MAIN_PRIO = CFG_IDX_W'(2);

  typedef enum logic [2:0] {
    OP_START   = 3'd0,
    OP_BLOCK   = 3'd1,
    OP_UNBLOCK = 3'd2,
    OP_YIELD   = 3'd3,
    OP_SCHED   = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_UNUSED  = 3'd0,
    ST_RUNNING = 3'd1,
    ST_READY   = 3'd2,
    ST_BLOCKED = 3'd3,
    ST_WAITING = 3'd4,
    ST_HANGING = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    ERR_OK            = 3'd0,
    ERR_IN_USE        = 3'd1,
    ERR_NOT_BLOCKED   = 3'd2,
    ERR_BAD_KIND      = 3'd3,
    ERR_NONE_RUNNABLE = 3'd4
  } err_e;

  typedef enum logic [1:0] {
    RD_CUR  = 2'd0,
    RD_SLOT = 2'd1,
    RD_IDLE = 2'd2
  } rd_sel_e;

  typedef enum logic [1:0] {
    WA_CUR  = 2'd0,
    WA_SLOT = 2'd1,
    WA_IDLE = 2'd2,
    WA_POP  = 2'd3
  } wa_sel_e;

  typedef enum logic [1:0] {
    SV_READY   = 2'd0,
    SV_RUNNING = 2'd1,
    SV_KIND    = 2'd2
  } sv_sel_e;

  typedef enum logic {
    PS_REQ    = 1'b0,
    PS_RELOAD = 1'b1
  } ps_src_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEC,
    S_START,
    S_UNB,
    S_BLK,
    S_YLD,
    S_SCH_RD,
    S_SCH,
    S_CNT,
    S_IDL,
    S_POP,
    S_RUN,
    S_FIN_RD,
    S_FIN
  } state_e;

  typedef struct packed {
    logic    latch_item;
    rd_sel_e rd_sel;
    wa_sel_e wa_sel;
    logic    st_we;
    sv_sel_e st_val;
    logic    ps_we;
    ps_src_e ps_src;
    logic    ring_app;
    logic    ring_front;
    logic    ring_pop;
    logic    pid_inc;
    logic    err_we;
    err_e    err_val;
    logic    set_run;
    logic    load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    op_e     op;
    logic    kind_bad;
    status_e ent_status;
    logic    count_zero;
    logic    out_free;
  } dp_status_t;

  function automatic logic is_blocked_kind(status_e st);
    return (st == ST_BLOCKED) || (st == ST_WAITING) || (st == ST_HANGING);
  endfunction

endpackage

// ===== rtl/rrts_ctrl.sv =====
// Sequencer that steps each scheduler operation through reads and writes of the slot tables.
module rrts_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rrts_pkg::dp_status_t status_i,
  output rrts_pkg::ctrl_cmd_t  cmd_o
);
  import rrts_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_item = 1'b1;
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        case (status_i.op)
          OP_START: begin
            cmd_o.rd_sel = RD_SLOT;
            state_d = S_START;
          end
          OP_BLOCK: begin
            cmd_o.rd_sel = RD_CUR;
            if (status_i.kind_bad) begin
              cmd_o.err_we  = 1'b1;
              cmd_o.err_val = ERR_BAD_KIND;
              state_d = S_FIN_RD;
            end else begin
              state_d = S_BLK;
            end
          end
          OP_UNBLOCK: begin
            cmd_o.rd_sel = RD_SLOT;
            state_d = S_UNB;
          end
          OP_YIELD: begin
            cmd_o.rd_sel = RD_CUR;
            state_d = S_YLD;
          end
          OP_SCHED: begin
            cmd_o.rd_sel = RD_CUR;
            state_d = S_SCH;
          end
          default: begin
            state_d = S_FIN_RD;
          end
        endcase
      end
      S_START: begin
        cmd_o.wa_sel = WA_SLOT;
        if (status_i.ent_status != ST_UNUSED) begin
          cmd_o.err_we  = 1'b1;
          cmd_o.err_val = ERR_IN_USE;
        end else begin
          cmd_o.pid_inc  = 1'b1;
          cmd_o.st_we    = 1'b1;
          cmd_o.st_val   = SV_READY;
          cmd_o.ps_we    = 1'b1;
          cmd_o.ps_src   = PS_REQ;
          cmd_o.ring_app = 1'b1;
        end
        state_d = S_FIN_RD;
      end
      S_UNB: begin
        cmd_o.wa_sel = WA_SLOT;
        if (!is_blocked_kind(status_i.ent_status)) begin
          cmd_o.err_we  = 1'b1;
          cmd_o.err_val = ERR_NOT_BLOCKED;
        end else begin
          cmd_o.ring_front = 1'b1;
          cmd_o.st_we      = 1'b1;
          cmd_o.st_val     = SV_READY;
        end
        state_d = S_FIN_RD;
      end
      S_BLK: begin
        cmd_o.wa_sel = WA_CUR;
        if (status_i.ent_status == ST_RUNNING || is_blocked_kind(status_i.ent_status)) begin
          cmd_o.st_we  = 1'b1;
          cmd_o.st_val = SV_KIND;
        end
        state_d = S_SCH_RD;
      end
      S_YLD: begin
        cmd_o.wa_sel = WA_CUR;
        if (status_i.ent_status == ST_RUNNING) begin
          cmd_o.ring_app = 1'b1;
          cmd_o.st_we    = 1'b1;
          cmd_o.st_val   = SV_READY;
        end
        state_d = S_SCH_RD;
      end
      S_SCH_RD: begin
        cmd_o.rd_sel = RD_CUR;
        state_d = S_SCH;
      end
      S_SCH: begin
        cmd_o.wa_sel = WA_CUR;
        if (status_i.ent_status == ST_RUNNING) begin
          cmd_o.ring_app = 1'b1;
          cmd_o.st_we    = 1'b1;
          cmd_o.st_val   = SV_READY;
          cmd_o.ps_we    = 1'b1;
          cmd_o.ps_src   = PS_RELOAD;
        end
        state_d = S_CNT;
      end
      S_CNT: begin
        cmd_o.rd_sel = RD_IDLE;
        state_d = status_i.count_zero ? S_IDL : S_POP;
      end
      S_IDL: begin
        cmd_o.wa_sel = WA_IDLE;
        if (!is_blocked_kind(status_i.ent_status)) begin
          cmd_o.err_we  = 1'b1;
          cmd_o.err_val = ERR_NONE_RUNNABLE;
          state_d = S_FIN_RD;
        end else begin
          cmd_o.ring_front = 1'b1;
          cmd_o.st_we      = 1'b1;
          cmd_o.st_val     = SV_READY;
          state_d = S_POP;
        end
      end
      S_POP: begin
        cmd_o.ring_pop = 1'b1;
        state_d = S_RUN;
      end
      S_RUN: begin
        cmd_o.wa_sel  = WA_POP;
        cmd_o.st_we   = 1'b1;
        cmd_o.st_val  = SV_RUNNING;
        cmd_o.set_run = 1'b1;
        state_d = S_FIN_RD;
      end
      S_FIN_RD: begin
        cmd_o.rd_sel = RD_CUR;
        state_d = S_FIN;
      end
      S_FIN: begin
        cmd_o.rd_sel = RD_CUR;
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/rrts_datapath.sv =====
// Slot tables, ready ring, scheduler registers, configuration and result register.
module rrts_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [2:0]                       op_i,
  input  logic [rrts_pkg::SLOT_W-1:0]      slot_i,
  input  logic [rrts_pkg::PRIO_W-1:0]      prio_i,
  input  logic [rrts_pkg::KIND_W-1:0]      kind_i,
  input  logic                             cfg_valid_i,
  input  logic [rrts_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [rrts_pkg::CFG_W-1:0]       cfg_data_i,
  input  rrts_pkg::ctrl_cmd_t              cmd_i,
  output rrts_pkg::dp_status_t             status_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [rrts_pkg::SLOT_W-1:0]      running_slot_o,
  output logic [rrts_pkg::SLOT_W-1:0]      previous_slot_o,
  output logic                             switched_o,
  output logic [rrts_pkg::PID_W-1:0]       assigned_pid_o,
  output logic [rrts_pkg::PRIO_W-1:0]      time_slice_o,
  output logic [2:0]                       error_code_o
);
  import rrts_pkg::*;

  logic [SLOT_W-1:0]  main_slot_q, idle_slot_q;
  logic [PRIO_W-1:0]  main_prio_q;
  logic [SLOT_W-1:0]  cur_q, head_q;
  logic [COUNT_W-1:0] count_q;
  logic [PID_W-1:0]   pid_q;

  op_e               op_q;
  logic [SLOT_W-1:0] slot_q, prev_q;
  logic [PRIO_W-1:0] prio_q;
  logic [KIND_W-1:0] kind_q;
  err_e              err_q;
  logic              sw_q;
  logic [PID_W-1:0]  pid_res_q;

  status_e             st_mem [NUM_SLOTS];
  logic [2*PRIO_W-1:0] ps_mem [NUM_SLOTS];
  logic [SLOT_W-1:0]   ring_mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] st_valid_q, ps_valid_q;

  status_e             st_rd_q, st_rst_q;
  logic                st_hit_q, ps_hit_q;
  logic [2*PRIO_W-1:0] ps_rd_q, ps_rst_q;
  logic [SLOT_W-1:0]   ring_rd_q;

  logic [SLOT_W-1:0]   rd_addr, wr_addr, ring_waddr;
  status_e             ent_status, st_wval;
  logic [2*PRIO_W-1:0] ent_ps, ps_wval;
  logic                restart, ring_room, ring_we;
  logic [SLOT_W-1:0]   new_main;

  logic                out_valid_q;
  logic [SLOT_W-1:0]   out_run_q, out_prev_q;
  logic                out_sw_q;
  logic [PID_W-1:0]    out_pid_q;
  logic [PRIO_W-1:0]   out_slice_q;
  err_e                out_err_q;

  assign restart  = cfg_valid_i &&
                    (cfg_index_i == CFG_MAIN_SLOT || cfg_index_i == CFG_MAIN_PRIO);
  assign new_main = (cfg_index_i == CFG_MAIN_SLOT) ? cfg_data_i[SLOT_W-1:0] : main_slot_q;

  always_comb begin
    case (cmd_i.rd_sel)
      RD_SLOT: rd_addr = slot_q;
      RD_IDLE: rd_addr = idle_slot_q;
      default: rd_addr = cur_q;
    endcase
    case (cmd_i.wa_sel)
      WA_SLOT: wr_addr = slot_q;
      WA_IDLE: wr_addr = idle_slot_q;
      WA_POP:  wr_addr = ring_rd_q;
      default: wr_addr = cur_q;
    endcase
    case (cmd_i.st_val)
      SV_RUNNING: st_wval = ST_RUNNING;
      SV_KIND:    st_wval = status_e'(3'(ST_BLOCKED) + {1'b0, kind_q});
      default:    st_wval = ST_READY;
    endcase
  end

  assign ent_status = st_hit_q ? st_rd_q : st_rst_q;
  assign ent_ps     = ps_hit_q ? ps_rd_q : ps_rst_q;
  assign ps_wval    = (cmd_i.ps_src == PS_RELOAD) ?
                      {ent_ps[2*PRIO_W-1:PRIO_W], ent_ps[2*PRIO_W-1:PRIO_W]} :
                      {prio_q, prio_q};

  assign ring_room  = (count_q != COUNT_W'(NUM_SLOTS));
  assign ring_we    = (cmd_i.ring_app || cmd_i.ring_front) && ring_room;
  assign ring_waddr = cmd_i.ring_front ? head_q - SLOT_W'(1) : head_q + count_q[SLOT_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.st_we) begin
      st_mem[wr_addr] <= st_wval;
    end
    if (cmd_i.ps_we) begin
      ps_mem[wr_addr] <= ps_wval;
    end
    if (ring_we) begin
      ring_mem[ring_waddr] <= (cmd_i.ring_front || cmd_i.wa_sel != WA_CUR) ? wr_addr : cur_q;
    end
    st_rd_q   <= st_mem[rd_addr];
    ps_rd_q   <= ps_mem[rd_addr];
    st_hit_q  <= st_valid_q[rd_addr];
    ps_hit_q  <= ps_valid_q[rd_addr];
    st_rst_q  <= (rd_addr == main_slot_q) ? ST_RUNNING : ST_UNUSED;
    ps_rst_q  <= (rd_addr == main_slot_q) ? {main_prio_q, main_prio_q} : '0;
    ring_rd_q <= ring_mem[head_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_slot_q <= MAIN_SLOT_RST;
      idle_slot_q <= IDLE_SLOT_RST;
      main_prio_q <= MAIN_PRIO_RST;
      cur_q       <= MAIN_SLOT_RST;
      head_q      <= '0;
      count_q     <= '0;
      pid_q       <= PID_RST;
      st_valid_q  <= '0;
      ps_valid_q  <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_MAIN_SLOT) begin
        main_slot_q <= cfg_data_i[SLOT_W-1:0];
      end
      if (cfg_index_i == CFG_IDLE_SLOT) begin
        idle_slot_q <= cfg_data_i[SLOT_W-1:0];
      end
      if (cfg_index_i == CFG_MAIN_PRIO) begin
        main_prio_q <= cfg_data_i[PRIO_W-1:0];
      end
      if (restart) begin
        cur_q      <= new_main;
        head_q     <= '0;
        count_q    <= '0;
        pid_q      <= PID_RST;
        st_valid_q <= '0;
        ps_valid_q <= '0;
      end
    end else begin
      if (cmd_i.st_we) begin
        st_valid_q[wr_addr] <= 1'b1;
      end
      if (cmd_i.ps_we) begin
        ps_valid_q[wr_addr] <= 1'b1;
      end
      if (cmd_i.pid_inc) begin
        pid_q <= pid_q + PID_W'(1);
      end
      if (cmd_i.set_run) begin
        cur_q <= ring_rd_q;
      end
      if (cmd_i.ring_pop) begin
        head_q  <= head_q + SLOT_W'(1);
        count_q <= count_q - COUNT_W'(1);
      end else if (ring_we) begin
        count_q <= count_q + COUNT_W'(1);
        if (cmd_i.ring_front) begin
          head_q <= head_q - SLOT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_item) begin
      op_q      <= op_e'(op_i);
      slot_q    <= slot_i;
      prio_q    <= prio_i;
      kind_q    <= kind_i;
      prev_q    <= cur_q;
      err_q     <= ERR_OK;
      sw_q      <= 1'b0;
      pid_res_q <= '0;
    end else begin
      if (cmd_i.err_we) begin
        err_q <= cmd_i.err_val;
      end
      if (cmd_i.set_run) begin
        sw_q <= 1'b1;
      end
      if (cmd_i.pid_inc) begin
        pid_res_q <= pid_q + PID_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_run_q   <= cur_q;
      out_prev_q  <= prev_q;
      out_sw_q    <= sw_q;
      out_pid_q   <= pid_res_q;
      out_slice_q <= ent_ps[PRIO_W-1:0];
      out_err_q   <= err_q;
    end
  end

  assign status_o.op         = op_q;
  assign status_o.kind_bad   = (kind_q == KIND_BAD);
  assign status_o.ent_status = ent_status;
  assign status_o.count_zero = (count_q == '0);
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign running_slot_o  = out_run_q;
  assign previous_slot_o = out_prev_q;
  assign switched_o      = out_sw_q;
  assign assigned_pid_o  = out_pid_q;
  assign time_slice_o    = out_slice_q;
  assign error_code_o    = 3'(out_err_q);

endmodule

// ===== rtl/round_robin_thread_scheduler.sv =====
// Top level of the round-robin thread scheduler: stream ports, configuration port and wiring.
// Items are taken one at a time: the next item is taken the cycle after the result of the last
// enters the output register, and an untaken result holds the sequencer in its last step.
// Reset clears the tables at once through per-slot valid bits; no clearing pass is needed.
module round_robin_thread_scheduler (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // thread_slot[3:0], priority_req[11:4], block_kind[13:12], zero fill
  input  logic [15:0]                    s_axis_tdata,
  // operation[2:0]
  input  logic [2:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // running_slot[3:0], previous_slot[7:4], switched[8], assigned_pid[24:9],
  // time_slice[32:25], error_code[35:33], zero fill
  output logic [39:0]                    m_axis_tdata,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rrts_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rrts_pkg::CFG_W-1:0]     cfg_data_i
);
  import rrts_pkg::*;

  ctrl_cmd_t         cmd;
  dp_status_t        status;
  logic [SLOT_W-1:0] run_slot, prev_slot;
  logic              switched;
  logic [PID_W-1:0]  pid;
  logic [PRIO_W-1:0] slice;
  logic [2:0]        err;

  assign cfg_ready_o = 1'b1;

  rrts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rrts_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .op_i            (s_axis_tuser),
    .slot_i          (s_axis_tdata[3:0]),
    .prio_i          (s_axis_tdata[11:4]),
    .kind_i          (s_axis_tdata[13:12]),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .running_slot_o  (run_slot),
    .previous_slot_o (prev_slot),
    .switched_o      (switched),
    .assigned_pid_o  (pid),
    .time_slice_o    (slice),
    .error_code_o    (err)
  );

  assign m_axis_tdata = {4'b0, err, slice, pid, switched, prev_slot, run_slot};

endmodule
